[rtl/skf_pkg.sv]
// Shared constants, register indexes and controller/datapath structs for the scalar Kalman filter
package skf_pkg;

	localparam int DATA_W    = 32;
	localparam int COV_W     = DATA_W - 1;
	localparam int GAIN_BITS = 16;
	localparam int GAIN_W    = GAIN_BITS + 1;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = GAIN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_START_EST  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_START_COV  = CFG_IDX_W'(3);

	localparam logic [COV_W-1:0]  PROC_NOISE_RST = COV_W'(66);
	localparam logic [COV_W-1:0]  MEAS_NOISE_RST = COV_W'(65536);
	localparam logic [DATA_W-1:0] START_EST_RST  = '0;
	localparam logic [COV_W-1:0]  START_COV_RST  = COV_W'(65536);

	typedef struct packed {
		logic accept;
		logic pred;
		logic div_step;
		logic div_first;
		logic mul;
		logic upd;
	} skf_cmd_t;

	typedef struct packed {
		logic out_busy;
	} skf_sts_t;

endpackage

[rtl/skf_if.sv]
// Valid/ready channel interfaces: sample input, result output, configuration write
interface skf_smp_if;
	import skf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample_value;
	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

interface skf_res_if;
	import skf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] filtered_value;
	logic [GAIN_W-1:0]        kalman_gain;
	logic [COV_W-1:0]         error_variance;
	modport source (output valid, output filtered_value, output kalman_gain,
		output error_variance, input ready);
	modport sink (input valid, input filtered_value, input kalman_gain,
		input error_variance, output ready);
endinterface

interface skf_cfg_if;
	import skf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/skf_ctrl.sv]
// Sequencing state machine: predict, restoring divide, multiply, update
module skf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_ready,
	input  skf_pkg::skf_sts_t sts,
	output skf_pkg::skf_cmd_t cmd
);
	import skf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PRED = 5'b00010,
		S_DIV  = 5'b00100,
		S_MUL  = 5'b01000,
		S_UPD  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;

	assign smp_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (smp_valid) begin
					cmd.accept = 1'b1;
					state_d = S_PRED;
				end
			end
			S_PRED: begin
				cmd.pred = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				if (!sts.out_busy) begin
					cmd.upd = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.pred)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

[rtl/skf_dpath.sv]
// Datapath: config registers, filter state, divider, multipliers, result register
module skf_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [skf_pkg::DATA_W-1:0] sample_value,
	input  skf_pkg::skf_cmd_t                 cmd,
	output skf_pkg::skf_sts_t                 sts,
	skf_cfg_if.sink                           cfg,
	skf_res_if.source                         res
);
	import skf_pkg::*;

	localparam int PROD_W = DATA_W + GAIN_W + 2;
	localparam int CPROD_W = COV_W + GAIN_W;

	logic [COV_W-1:0]          proc_noise_q, meas_noise_q, start_cov_q, cov_q, p_q;
	logic [DATA_W-1:0]         start_est_q;
	logic signed [DATA_W-1:0]  est_q, smp_q;
	logic [DATA_W-1:0]         denom_q, rem_q;
	logic                      dzero_q;
	logic signed [DATA_W:0]    innov_q;
	logic [GAIN_W-1:0]         quo_q, gain_q;
	logic signed [PROD_W-1:0]  dprod_q;
	logic [CPROD_W-1:0]        cprod_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  filt_q;
	logic [COV_W-1:0]          evar_q;

	logic [DATA_W-1:0]         p_sum, denom_c;
	logic [COV_W-1:0]          p_sat;
	logic [DATA_W:0]           rem_sh;
	logic [DATA_W+1:0]         diff;
	logic                      qbit;
	logic [GAIN_W-1:0]         gain_c;
	logic signed [PROD_W-1:0]  sum_c;
	logic                      ovf;
	logic signed [DATA_W-1:0]  est_new;
	logic [COV_W-1:0]          cov_new;
	logic                      cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid && cfg.ready;

	// predict, saturating
	assign p_sum = {1'b0, cov_q} + {1'b0, proc_noise_q};
	assign p_sat = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
	assign denom_c = {1'b0, p_sat} + {1'b0, meas_noise_q};

	// restoring divide, numerator p << GAIN_BITS
	assign rem_sh = {rem_q, cmd.div_first ? p_q[0] : 1'b0};
	assign diff = {1'b0, rem_sh} - {2'b00, denom_q};
	assign qbit = !diff[DATA_W+1];

	assign gain_c = dzero_q ? '0 : quo_q;

	// floor shift then saturate to the signed range
	assign sum_c = (dprod_q >>> GAIN_BITS) + PROD_W'(est_q);
	assign ovf = !((&sum_c[PROD_W-1:DATA_W-1]) || !(|sum_c[PROD_W-1:DATA_W-1]));
	assign est_new = !ovf ? sum_c[DATA_W-1:0] :
		sum_c[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	// p*(1-gain) never exceeds p
	assign cov_new = cprod_q[COV_W+GAIN_BITS-1:GAIN_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_noise_q <= PROC_NOISE_RST;
			meas_noise_q <= MEAS_NOISE_RST;
			start_est_q <= START_EST_RST;
			start_cov_q <= START_COV_RST;
			est_q <= START_EST_RST;
			cov_q <= START_COV_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg.index)
					REG_PROC_NOISE: proc_noise_q <= cfg.wdata[COV_W-1:0];
					REG_MEAS_NOISE: meas_noise_q <= cfg.wdata[COV_W-1:0];
					REG_START_EST: begin
						start_est_q <= cfg.wdata;
						est_q <= cfg.wdata;
						cov_q <= start_cov_q;
					end
					REG_START_COV: begin
						start_cov_q <= cfg.wdata[COV_W-1:0];
						cov_q <= cfg.wdata[COV_W-1:0];
						est_q <= start_est_q;
					end
					default: ;
				endcase
			end else if (cmd.upd) begin
				est_q <= est_new;
				cov_q <= cov_new;
			end
			if (cmd.upd)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			smp_q <= sample_value;
		if (cmd.pred) begin
			p_q <= p_sat;
			denom_q <= denom_c;
			dzero_q <= (denom_c == '0);
			innov_q <= {smp_q[DATA_W-1], smp_q} - {est_q[DATA_W-1], est_q};
			rem_q <= {2'b00, p_sat[COV_W-1:1]};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], qbit};
		end
		if (cmd.mul) begin
			dprod_q <= innov_q * $signed({1'b0, gain_c});
			cprod_q <= p_q * (GAIN_ONE - gain_c);
		end
		if (cmd.upd) begin
			filt_q <= est_new;
			gain_q <= gain_c;
			evar_q <= cov_new;
		end
	end

	assign sts.out_busy = out_valid_q && !res.ready;

	assign res.valid = out_valid_q;
	assign res.filtered_value = filt_q;
	assign res.kalman_gain = gain_q;
	assign res.error_variance = evar_q;

endmodule

[rtl/scalar_kalman_filter.sv]
// Top level of the scalar Kalman filter: controller, datapath and checks
//
//  channel  dir  handshake      word
//  smp      in   valid/ready    sample_value
//  res      out  valid/ready    filtered_value, kalman_gain, error_variance
//  cfg      in   valid/ready    index, wdata (always ready)
//
// Each word passes through accept, predict, 17 restoring divider steps
// (one gain bit each), multiply and update; result valid after update.
// Next sample is accepted when the controller is back in idle; a result held
// in the output register does not block it, only the next update waits.
// Reset loads the default noise values and the start estimate/covariance.
module scalar_kalman_filter (
	input logic       clk,
	input logic       arst_n,
	skf_smp_if.sink   smp,
	skf_res_if.source res,
	skf_cfg_if.sink   cfg
);
	import skf_pkg::*;

	skf_cmd_t cmd;
	skf_sts_t sts;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp.valid),
		.smp_ready (smp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skf_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (smp.sample_value),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.res          (res)
	);

`ifndef ASSERT_OFF
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.kalman_gain <= GAIN_ONE)
		else $error("gain above one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(smp.valid && smp.ready) |=> !smp.ready)
		else $error("sample taken while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !(res.valid && !res.ready))
		else $error("result overwritten");
`endif

endmodule

[test/scalar_kalman_filter_checker.sv]
// Checker for the scalar Kalman filter: tracks config writes, predicts each result word, compares
module scalar_kalman_filter_checker
	import skf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	skf_smp_if          smp,
	skf_res_if          res,
	skf_cfg_if          cfg,
	output int unsigned fails,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned COV_MAX  = (64'd1 << COV_W) - 1;
	localparam longint signed   DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint signed   DATA_MIN = -DATA_MAX - 1;
	localparam int              MAX_REPORTS = 40;

	typedef struct packed {
		logic signed [DATA_W-1:0] filtered_value;
		logic [GAIN_W-1:0]        kalman_gain;
		logic [COV_W-1:0]         error_variance;
	} kf_word_t;

	logic [COV_W-1:0]         proc_noise_q;
	logic [COV_W-1:0]         meas_noise_q;
	logic signed [DATA_W-1:0] start_est_q;
	logic [COV_W-1:0]         start_cov_q;
	logic signed [DATA_W-1:0] est_q;
	logic [COV_W-1:0]         cov_q;
	kf_word_t                 expected_words[$];

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic void reload_state();
		est_q = start_est_q;
		cov_q = start_cov_q;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		case (idx)
			REG_PROC_NOISE: proc_noise_q = data[COV_W-1:0];
			REG_MEAS_NOISE: meas_noise_q = data[COV_W-1:0];
			REG_START_EST: begin
				start_est_q = data;
				reload_state();
			end
			REG_START_COV: begin
				start_cov_q = data[COV_W-1:0];
				reload_state();
			end
			default: ;
		endcase
	endfunction

	// predict, gain, then estimate and covariance update
	function automatic kf_word_t filter_update(input logic signed [DATA_W-1:0] meas);
		longint unsigned prior;
		longint unsigned denom;
		longint unsigned gain;
		longint unsigned post;
		longint signed   innov;
		longint signed   moved;
		kf_word_t        word;
		prior = 64'(cov_q) + 64'(proc_noise_q);
		if (prior > COV_MAX)
			prior = COV_MAX;
		denom = prior + 64'(meas_noise_q);
		gain = (denom == 0) ? 64'd0 : (prior << GAIN_BITS) / denom;
		if (gain > 64'(GAIN_ONE))
			gain = 64'(GAIN_ONE);
		innov = longint'(meas) - longint'(est_q);
		// arithmetic shift floors toward minus infinity
		moved = longint'(est_q) + ((innov * longint'(gain)) >>> GAIN_BITS);
		if (moved > DATA_MAX)
			moved = DATA_MAX;
		if (moved < DATA_MIN)
			moved = DATA_MIN;
		post = (prior * (64'(GAIN_ONE) - gain)) >> GAIN_BITS;
		if (post > COV_MAX)
			post = COV_MAX;
		est_q = moved[DATA_W-1:0];
		cov_q = post[COV_W-1:0];
		word.filtered_value = est_q;
		word.kalman_gain    = gain[GAIN_W-1:0];
		word.error_variance = cov_q;
		return word;
	endfunction

	task automatic compare_field(input string name, input longint signed exp_v,
		input longint signed act_v);
		if (exp_v != act_v) begin
			if (fails < MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	task automatic check_word();
		kf_word_t exp_w;
		if (expected_words.size() == 0) begin
			if (fails < MAX_REPORTS)
				$display("%0t: result word with none expected, actual %0d/%0d/%0d", $time,
					res.filtered_value, res.kalman_gain, res.error_variance);
			fails++;
		end else begin
			exp_w = expected_words.pop_front();
			compare_field("filtered_value", longint'(exp_w.filtered_value),
				longint'(res.filtered_value));
			compare_field("kalman_gain", longint'(exp_w.kalman_gain),
				longint'(res.kalman_gain));
			compare_field("error_variance", longint'(exp_w.error_variance),
				longint'(res.error_variance));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_noise_q = PROC_NOISE_RST;
			meas_noise_q = MEAS_NOISE_RST;
			start_est_q  = START_EST_RST;
			start_cov_q  = START_COV_RST;
			reload_state();
			expected_words.delete();
		end else begin
			if (res.valid && res.ready)
				check_word();
			if (cfg.valid && cfg.ready)
				apply_write(cfg.index, cfg.wdata);
			if (smp.valid && smp.ready)
				expected_words.push_back(filter_update(smp.sample_value));
		end
		pending = expected_words.size();
	end

endmodule

[test/scalar_kalman_filter_test.sv]
// Testbench top for the scalar Kalman filter: clock, reset, sample/config stimulus, verdict
module scalar_kalman_filter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import skf_pkg::*;

	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0]        COV_TOP = DATA_W'({COV_W{1'b1}});
	localparam logic [DATA_W-1:0]        ONE_Q16 = DATA_W'(1) << 16;
	localparam int RAND_PHASES  = 28;
	localparam int PHASE_WORDS  = 50;
	localparam int MAX_IDLE     = 11;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	bit          smp_idle_on;
	bit          res_idle_on;
	int unsigned fail_count;
	int unsigned pending_words;
	int unsigned quiet_cycles;

	skf_smp_if smp_ch();
	skf_res_if res_ch();
	skf_cfg_if cfg_ch();

	scalar_kalman_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	scalar_kalman_filter_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (smp_ch),
		.res     (res_ch),
		.cfg     (cfg_ch),
		.fails   (fail_count),
		.pending (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall after each accepted word when res_idle_on is set
	initial begin
		int unsigned stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = (stall == 0);
			if (stall != 0)
				stall--;
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				stall = res_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2: return DATA_W'($urandom_range(0, 32'h0010_0000)) - DATA_W'(32'h0008_0000);
			3, 4: return DATA_W'($urandom_range(0, 32'h0200_0000)) - DATA_W'(32'h0100_0000);
			default: return $urandom();
		endcase
	endfunction

	// covariance-format value; top bit of the word is don't-care and randomized
	function automatic logic [DATA_W-1:0] pick_cov();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = COV_TOP;
			2, 3, 4, 5: v = DATA_W'($urandom_range(0, 32'h0010_0000));
			default: v = $urandom() & COV_TOP;
		endcase
		return v | ($urandom() & ~COV_TOP);
	endfunction

	task automatic send_sample(input logic signed [DATA_W-1:0] v);
		int unsigned gap;
		gap = smp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			smp_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_ch.valid = 1'b1;
		smp_ch.sample_value = v;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.wdata = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// stop sending and let every expected word come back before touching config
	task automatic drain();
		smp_ch.valid = 1'b0;
		while (pending_words != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned mode;
		smp_ch.valid = 1'b0;
		smp_ch.sample_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		arst_n = 1'b0;
		smp_idle_on = 1'b1;
		res_idle_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults, field extremes
		send_sample('0);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample('1);
		send_sample(DATA_W'(1));

		// write to an unmapped index must change nothing
		drain();
		write_reg(REG_START_COV + CFG_IDX_W'(2), '1);
		send_sample(ONE_Q16);

		// predict overflow: P + Q clips at full scale
		drain();
		write_reg(REG_PROC_NOISE, COV_TOP);
		write_reg(REG_START_COV, '1);
		send_sample(S_MAX);
		send_sample(S_MIN);

		// zero denominator: gain forced to zero, state holds
		drain();
		write_reg(REG_PROC_NOISE, '0);
		write_reg(REG_MEAS_NOISE, '0);
		write_reg(REG_START_EST, S_MIN);
		write_reg(REG_START_COV, '0);
		send_sample(S_MAX);
		send_sample('0);

		// no measurement noise: gain of exactly one
		drain();
		write_reg(REG_PROC_NOISE, ONE_Q16);
		write_reg(REG_START_COV, DATA_W'(1));
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(DATA_W'(12345));

		// huge measurement noise, estimate at the top
		drain();
		write_reg(REG_MEAS_NOISE, COV_TOP);
		write_reg(REG_START_EST, S_MAX);
		send_sample(S_MIN);
		send_sample('1);

		// estimate reload with a negative start
		drain();
		write_reg(REG_START_EST, 32'hFFFF_8000);
		send_sample(ONE_Q16);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			mode = $urandom_range(0, 3);
			smp_idle_on = mode[0];
			res_idle_on = mode[1];
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_PROC_NOISE, pick_cov());
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_MEAS_NOISE, pick_cov());
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_START_EST, pick_sample());
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_START_COV, pick_cov());
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_START_COV + CFG_IDX_W'($urandom_range(1, 4)), $urandom());
			repeat (PHASE_WORDS)
				send_sample(pick_sample());
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/skf_ctrl.sv
rtl/skf_dpath.sv
rtl/scalar_kalman_filter.sv
test/scalar_kalman_filter_checker.sv
test/scalar_kalman_filter_test.sv
